FILE: sv/crc8sfr_pkg.sv
package crc8sfr_pkg;

  // Largest payload the block is built for; the limit in force never exceeds it.
  localparam int unsigned MAX_PAYLOAD = 64;
  localparam logic [6:0]  LEN_CAP     = (MAX_PAYLOAD > 127) ? 7'd127 : 7'(MAX_PAYLOAD);

  localparam int unsigned ADDR_W = 2;
  localparam int unsigned DATA_W = 32;
  localparam logic [ADDR_W-1:0] ADDR_MAX_LENGTH = '0;
  localparam logic [6:0] MAX_LENGTH_RST = 7'd64;

  localparam logic [7:0] CRC_POLY = 8'h8C;
  localparam logic [7:0] HDR0     = 8'h55;
  localparam logic [7:0] HDR1     = 8'hAA;
  localparam logic [7:0] END0     = 8'h0D;
  localparam logic [7:0] END1     = 8'h0A;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_CRC_ERR  = 3'd1;
  localparam logic [2:0] ST_BAD_END  = 3'd2;
  localparam logic [2:0] ST_UNKNOWN  = 3'd3;
  localparam logic [2:0] ST_TOO_LONG = 3'd4;

  localparam logic [15:0] CMD_CODES [8] = '{
    16'd23130, 16'd23125, 16'd23210, 16'd23205,
    16'd42330, 16'd42325, 16'd42410, 16'd42405
  };

  // One byte held in the input register.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } stage_t;

  typedef struct packed {
    logic       known;
    logic [2:0] cls;
  } class_t;

  // Reflected CRC-8 update over one byte, LSB first.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // First matching code wins; an unknown code gives class zero.
  function automatic class_t classify(input logic [15:0] code);
    class_t r;
    r = '0;
    for (int k = 7; k >= 0; k--) begin
      if (CMD_CODES[k] == code) begin
        r.known = 1'b1;
        r.cls   = 3'(k);
      end
    end
    return r;
  endfunction

endpackage

FILE: sv/crc8sfr_ifs.sv
interface crc8sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source(output valid, output rx_byte, input ready);
  modport sink(input valid, input rx_byte, output ready);
endinterface

interface crc8sfr_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] payload_byte;
  logic [5:0] byte_index;
  logic [2:0] status;
  logic [2:0] command_class;
  logic [6:0] frame_length;

  modport source(output valid, output kind, output payload_byte, output byte_index,
                 output status, output command_class, output frame_length, input ready);
  modport sink(input valid, input kind, input payload_byte, input byte_index,
               input status, input command_class, input frame_length, output ready);
endinterface

FILE: sv/crc8sfr_cfg.sv
module crc8sfr_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [crc8sfr_pkg::ADDR_W-1:0] paddr,
  input  logic [crc8sfr_pkg::DATA_W-1:0] pwdata,
  output logic [crc8sfr_pkg::DATA_W-1:0] prdata,
  output logic                          pready,
  output logic [6:0]                    max_length_o
);
  import crc8sfr_pkg::*;

  logic [6:0] max_length_q;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr == ADDR_MAX_LENGTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= MAX_LENGTH_RST;
    end else if (wr_en) begin
      max_length_q <= pwdata[6:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_MAX_LENGTH) begin
      prdata = {{(DATA_W-7){1'b0}}, max_length_q};
    end
  end

  assign max_length_o = max_length_q;

endmodule

FILE: sv/crc8sfr_in_stage.sv
module crc8sfr_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  crc8sfr_in_if.sink          rx_i,
  input  logic                take_i,
  output crc8sfr_pkg::stage_t stage_o
);
  import crc8sfr_pkg::*;

  logic       valid_q;
  logic [7:0] data_q;
  logic       load;

  // The register can refill in the same cycle that its byte moves on.
  assign rx_i.ready = !valid_q || take_i;
  assign load       = rx_i.valid && rx_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      data_q  <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        data_q  <= rx_i.rx_byte;
      end else if (take_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.data  = data_q;

endmodule

FILE: sv/crc8sfr_deframer.sv
module crc8sfr_deframer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  crc8sfr_pkg::stage_t stage_i,
  input  logic [6:0]          max_length_i,
  output logic                take_o,
  crc8sfr_out_if.source       res_o
);
  import crc8sfr_pkg::*;

  typedef enum logic [3:0] {
    PH_HUNT0, PH_HUNT1, PH_CMDLO, PH_CMDHI, PH_LEN,
    PH_DATA, PH_CRC, PH_END0, PH_END1
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  crc_q, crc_d;
  logic [15:0] cmd_q, cmd_d;
  logic [6:0]  len_q, len_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [7:0]  rcrc_q, rcrc_d;
  logic        end0_ok_q, end0_ok_d;

  logic        ov_q;
  logic        kind_q, kind_d;
  logic [7:0]  pb_q, pb_d;
  logic [5:0]  idx_q, idx_d;
  logic [2:0]  st_q, st_d;
  logic [2:0]  cls_q, cls_d;
  logic [6:0]  flen_q, flen_d;
  logic        has_res;

  logic [7:0]  b;
  logic [7:0]  crc_b;
  logic [6:0]  limit;
  logic [6:0]  len_sat;
  logic [6:0]  cnt_inc;
  class_t      cmd_cls;

  assign take_o  = stage_i.valid && (!ov_q || res_o.ready);
  assign b       = stage_i.data;
  assign crc_b   = crc8_step(crc_q, b);
  assign limit   = (max_length_i > LEN_CAP) ? LEN_CAP : max_length_i;
  assign len_sat = b[7] ? 7'd127 : b[6:0];
  assign cnt_inc = cnt_q + 7'd1;
  assign cmd_cls = classify(cmd_q);

  always_comb begin
    phase_d   = phase_q;
    crc_d     = crc_q;
    cmd_d     = cmd_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    rcrc_d    = rcrc_q;
    end0_ok_d = end0_ok_q;
    has_res   = 1'b0;
    kind_d    = KIND_DATA;
    pb_d      = '0;
    idx_d     = '0;
    st_d      = ST_OK;
    cls_d     = '0;
    flen_d    = len_q;
    case (phase_q)
      PH_HUNT1: begin
        if (b == HDR1) begin
          crc_d   = crc_b;
          phase_d = PH_CMDLO;
        end else if (b == HDR0) begin
          crc_d = crc8_step(8'h00, b);
        end else begin
          phase_d = PH_HUNT0;
        end
      end
      PH_CMDLO: begin
        crc_d   = crc_b;
        cmd_d   = {8'h00, b};
        phase_d = PH_CMDHI;
      end
      PH_CMDHI: begin
        crc_d   = crc_b;
        cmd_d   = {b, cmd_q[7:0]};
        phase_d = PH_LEN;
      end
      PH_LEN: begin
        crc_d = crc_b;
        len_d = len_sat;
        cnt_d = '0;
        if (b > {1'b0, limit}) begin
          has_res = 1'b1;
          kind_d  = KIND_STATUS;
          st_d    = ST_TOO_LONG;
          cls_d   = cmd_cls.cls;
          flen_d  = len_sat;
          phase_d = PH_HUNT0;
        end else begin
          phase_d = (len_sat == 7'd0) ? PH_CRC : PH_DATA;
        end
      end
      PH_DATA: begin
        crc_d   = crc_b;
        has_res = 1'b1;
        pb_d    = b;
        idx_d   = cnt_q[5:0];
        cnt_d   = cnt_inc;
        if (cnt_inc >= len_q) begin
          phase_d = PH_CRC;
        end
      end
      PH_CRC: begin
        rcrc_d  = b;
        phase_d = PH_END0;
      end
      PH_END0: begin
        end0_ok_d = (b == END0);
        phase_d   = PH_END1;
      end
      PH_END1: begin
        has_res = 1'b1;
        kind_d  = KIND_STATUS;
        cls_d   = cmd_cls.cls;
        if (!cmd_cls.known) begin
          st_d = ST_UNKNOWN;
        end else if (!end0_ok_q || (b != END1)) begin
          st_d = ST_BAD_END;
        end else if (rcrc_q != crc_q) begin
          st_d = ST_CRC_ERR;
        end else begin
          st_d = ST_OK;
        end
        phase_d = PH_HUNT0;
      end
      default: begin
        phase_d = PH_HUNT0;
        if (b == HDR0) begin
          crc_d   = crc8_step(8'h00, b);
          phase_d = PH_HUNT1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT0;
      crc_q     <= '0;
      cmd_q     <= '0;
      len_q     <= '0;
      cnt_q     <= '0;
      rcrc_q    <= '0;
      end0_ok_q <= 1'b0;
      ov_q      <= 1'b0;
      kind_q    <= KIND_DATA;
      pb_q      <= '0;
      idx_q     <= '0;
      st_q      <= ST_OK;
      cls_q     <= '0;
      flen_q    <= '0;
    end else begin
      if (take_o) begin
        phase_q   <= phase_d;
        crc_q     <= crc_d;
        cmd_q     <= cmd_d;
        len_q     <= len_d;
        cnt_q     <= cnt_d;
        rcrc_q    <= rcrc_d;
        end0_ok_q <= end0_ok_d;
        ov_q      <= has_res;
        if (has_res) begin
          kind_q <= kind_d;
          pb_q   <= pb_d;
          idx_q  <= idx_d;
          st_q   <= st_d;
          cls_q  <= cls_d;
          flen_q <= flen_d;
        end
      end else if (res_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign res_o.valid         = ov_q;
  assign res_o.kind          = kind_q;
  assign res_o.payload_byte  = pb_q;
  assign res_o.byte_index    = idx_q;
  assign res_o.status        = st_q;
  assign res_o.command_class = cls_q;
  assign res_o.frame_length  = flen_q;

  // While payload is streaming, the count has not yet reached the length.
  a_data_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (cnt_q < len_q))
    else $error("payload count reached length while still in the data phase");

  // A payload item always lies inside the frame it reports.
  a_index_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && (kind_q == KIND_DATA)) |-> ({1'b0, idx_q} < flen_q))
    else $error("payload byte index outside the frame length");

  // The second ender byte always closes the frame with a status item.
  a_end_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_o && (phase_q == PH_END1)) |=>
      ((phase_q == PH_HUNT0) && ov_q && (kind_q == KIND_STATUS)))
    else $error("frame end did not yield a status item");

  // Bytes are never taken in while an untaken result would be overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !res_o.ready) |=> ($stable(st_q) && $stable(pb_q) && ov_q))
    else $error("pending result changed before it was taken");

endmodule

FILE: sv/crc8_serial_frame_receiver_top.sv
// Channel   Dir  Handshake        Payload
// rx_i      in   valid / ready    rx_byte[7:0]
// res_o     out  valid / ready    kind, payload_byte, byte_index, status,
//                                 command_class, frame_length
// APB       in   psel / penable   max_length at byte address 0 (7 bits, reset 64)
//
// A byte is decoded while it sits in the input register, and its result is
// registered onto res_o. The frame decoder with its one-byte CRC update sets
// the rate: one byte per cycle while no result waits on res_o.ready.
// Reset is asynchronous and active low; it returns the decoder to header hunt.
// A result held by res_o.ready low stops the decoder, and rx_i.ready falls as
// soon as the input register holds a byte.
module crc8_serial_frame_receiver_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  crc8sfr_in_if.sink                     rx_i,
  crc8sfr_out_if.source                  res_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [crc8sfr_pkg::ADDR_W-1:0] paddr,
  input  logic [crc8sfr_pkg::DATA_W-1:0] pwdata,
  output logic [crc8sfr_pkg::DATA_W-1:0] prdata,
  output logic                           pready
);
  import crc8sfr_pkg::*;

  stage_t     stage;
  logic       take;
  logic [6:0] max_length;

  // Register file: holds the payload length limit.
  crc8sfr_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .max_length_o (max_length)
  );

  // Input register: decouples the byte source from the decoder.
  crc8sfr_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx_i),
    .take_i  (take),
    .stage_o (stage)
  );

  // Frame decoder: header hunt, CRC, length check and the result register.
  crc8sfr_deframer u_dfr (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .stage_i      (stage),
    .max_length_i (max_length),
    .take_o       (take),
    .res_o        (res_o)
  );

endmodule
